[hdl/fsht_pkg.sv]
// ----------------------------------------------------------------------------
// fsht_pkg: shared types and constants of the free-slot handle table
// Holds the table size, the request and response types, and the command and
// status codes.
// ----------------------------------------------------------------------------
package fsht_pkg;

    localparam int SLOTS       = 256;
    localparam int VALUE_WIDTH = 32;

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int STORE_W = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_FIND   = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_MISMATCH = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] value;
        logic [7:0]  slot_index;
    } fsht_req_t;

    typedef struct packed {
        logic [7:0] result_index;
        logic [1:0] status;
    } fsht_rsp_t;

endpackage

[hdl/fsht_ram.sv]
// ----------------------------------------------------------------------------
// fsht_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module fsht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/free_slot_handle_table_core.sv]
// ----------------------------------------------------------------------------
// free_slot_handle_table_core: handle table with a lowest-free hint
// Adds, removes and finds handle values in a table of slots.
// ----------------------------------------------------------------------------
// Requests arrive on req with req_valid/req_ready; each request gives exactly
// one response on rsp with rsp_valid/rsp_ready. A request carries a command
// (add, remove, find), a value and a slot index.
// The block works on one request at a time. A single compare unit probes one
// slot of the table RAM at a time: S_RD presents the address and S_CMP
// compares the registered data. Add probes from the free hint upward, find
// from the high mark downward, and remove probes one slot. Commands that
// need no probe go straight to the response state.
// A full add or a find that misses probes up to SLOTS - 1 slots.
// Reset clears the state, the free hint, the high mark and the response
// valid flag; per-slot valid bits make every slot read as empty, so no
// clearing pass is needed and the block is ready at once.
// The response sits in an output register. A new request is accepted while
// it waits; a finished response is held inside until the receiver takes the
// previous one.
// ----------------------------------------------------------------------------
module free_slot_handle_table_core
    import fsht_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  fsht_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output fsht_rsp_t rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [1:0]         cmd_reg, cmd_next;
    logic [STORE_W-1:0] val_reg, val_next;
    logic [IDX_W:0]     scan_reg, scan_next;
    logic [IDX_W-1:0]   res_reg, res_next;
    logic [1:0]         stat_reg, stat_next;
    logic [IDX_W-1:0]   hint_reg, hint_next;
    logic [IDX_W:0]     mark_reg, mark_next;
    fsht_rsp_t          rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic               vld_reg [SLOTS];
    logic               rvld_reg;

    logic               req_fire;
    logic               idx_bad;
    logic [IDX_W-1:0]   addr;
    logic [IDX_W:0]     scan_inc;
    logic [STORE_W-1:0] rdata;
    logic [STORE_W-1:0] slot_val;
    logic               we;
    logic [STORE_W-1:0] wdata;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign idx_bad   = (req.slot_index == 8'd0) || (32'(req.slot_index) >= 32'(SLOTS));
    assign addr      = scan_reg[IDX_W-1:0];
    assign scan_inc  = scan_reg + 1'b1;
    assign slot_val  = rvld_reg ? rdata : '0;

    fsht_ram #(
        .WIDTH (STORE_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (addr),
        .wdata (wdata),
        .raddr (addr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        scan_next      = scan_reg;
        res_next       = res_reg;
        stat_next      = stat_reg;
        hint_next      = hint_reg;
        mark_next      = mark_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        we             = 1'b0;
        wdata          = val_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    cmd_next   = req.command;
                    val_next   = req.value[STORE_W-1:0];
                    res_next   = '0;
                    stat_next  = STAT_OK;
                    state_next = S_DONE;
                    unique case (req.command)
                        CMD_ADD:
                        begin
                            scan_next  = {1'b0, hint_reg};
                            state_next = S_RD;
                        end
                        CMD_REMOVE:
                        begin
                            if (idx_bad)
                            begin
                                stat_next = STAT_MISMATCH;
                            end
                            else
                            begin
                                scan_next  = (IDX_W+1)'(req.slot_index);
                                state_next = S_RD;
                            end
                        end
                        CMD_FIND:
                        begin
                            if (mark_reg > (IDX_W+1)'(1))
                            begin
                                scan_next  = mark_reg - 1'b1;
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_DONE;
                unique case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (slot_val == '0)
                        begin
                            we       = 1'b1;
                            res_next = addr;
                            if (mark_reg < scan_inc)
                            begin
                                mark_next = scan_inc;
                            end
                        end
                        else if (scan_inc == (IDX_W+1)'(SLOTS))
                        begin
                            stat_next = STAT_FULL;
                        end
                        else
                        begin
                            scan_next  = scan_inc;
                            state_next = S_RD;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (slot_val == val_reg)
                        begin
                            we    = 1'b1;
                            wdata = '0;
                            if (addr < hint_reg)
                            begin
                                hint_next = addr;
                            end
                            if (mark_reg < scan_inc)
                            begin
                                mark_next = scan_inc;
                            end
                        end
                        else
                        begin
                            stat_next = STAT_MISMATCH;
                        end
                    end
                    default:
                    begin
                        if (slot_val == val_reg)
                        begin
                            res_next = addr;
                        end
                        else if (scan_reg != (IDX_W+1)'(1))
                        begin
                            scan_next  = scan_reg - 1'b1;
                            state_next = S_RD;
                        end
                    end
                endcase
            end
            default:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.result_index = 8'(res_reg);
                    rsp_next.status       = stat_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hint_reg      <= IDX_W'(1);
            mark_reg      <= (IDX_W+1)'(1);
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            mark_reg      <= mark_next;
            rsp_valid_reg <= rsp_valid_next;
            if (we)
            begin
                vld_reg[addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        val_reg  <= val_next;
        scan_reg <= scan_next;
        res_reg  <= res_next;
        stat_reg <= stat_next;
        rsp_reg  <= rsp_next;
        rvld_reg <= vld_reg[addr];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_hint_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        hint_reg != '0)
        else $error("free hint points at the reserved slot");

    a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mark_reg != '0) && (mark_reg <= (IDX_W+1)'(SLOTS)))
        else $error("high mark out of range");

    a_full_no_index: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == STAT_FULL) |-> (rsp.result_index == 8'd0))
        else $error("full response carries a slot index");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg != S_IDLE))
        else $error("request accepted without starting work");
`endif

endmodule

[verif/free_slot_handle_table_core_test.sv]
// ----------------------------------------------------------------------------
// free_slot_handle_table_core_test: self-checking bench for the handle table
// Requests are planned up front against a planning copy of the table, then
// fed by a clocked driver with random idle bursts. A second copy of the
// table is updated as each request is accepted. The monitor compares every
// response with the oldest predicted one, while the receiver stalls at
// random and once holds off long enough to back up the request side.
// ----------------------------------------------------------------------------
module free_slot_handle_table_core_test;
    import fsht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int PLAN = 0;
    localparam int LIVE = 1;
    localparam int RANDOM_ITEMS = 1150;
    localparam int QUIET_TAIL = 150;
    localparam int HOLD_AFTER = 400;
    localparam int HOLD_LEN = 300;
    localparam int CYCLE_LIMIT = 4000000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    fsht_req_t req = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    fsht_rsp_t rsp;

    logic [31:0] slot_vals [2][SLOTS];
    int unsigned low_free [2];
    int unsigned top_mark [2];

    fsht_req_t queued_requests [$];
    fsht_rsp_t predicted_responses [$];

    int request_total = 0;
    int item_count = 0;
    int adds_sent = 0;
    int removes_sent = 0;
    int finds_sent = 0;
    int others_sent = 0;
    int responses_seen = 0;
    int ok_seen = 0;
    int mismatch_seen = 0;
    int full_seen = 0;
    int error_count = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_cycles = 0;
    int cycle_count = 0;
    logic hold_active = 1'b0;
    logic hold_done = 1'b0;

    free_slot_handle_table_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    function automatic fsht_rsp_t apply_table_op(input int c, input fsht_req_t r);
        fsht_rsp_t o;
        int k;
        int top;
        bit done;
        o.result_index = '0;
        o.status = STAT_OK;
        done = 1'b0;
        case (r.command)
            CMD_ADD:
            begin
                for (k = int'(low_free[c]); k < SLOTS && !done; k++)
                begin
                    if (slot_vals[c][k] == '0)
                    begin
                        slot_vals[c][k] = r.value;
                        if (top_mark[c] < k + 1)
                            top_mark[c] = k + 1;
                        o.result_index = 8'(k);
                        done = 1'b1;
                    end
                end
                if (!done)
                    o.status = STAT_FULL;
            end
            CMD_REMOVE:
            begin
                if (r.slot_index == 0 || int'(r.slot_index) >= SLOTS
                    || slot_vals[c][r.slot_index] != r.value)
                    o.status = STAT_MISMATCH;
                else
                begin
                    slot_vals[c][r.slot_index] = '0;
                    if (r.slot_index < low_free[c])
                        low_free[c] = r.slot_index;
                    if (top_mark[c] < r.slot_index + 1)
                        top_mark[c] = r.slot_index + 1;
                end
            end
            CMD_FIND:
            begin
                top = (top_mark[c] > SLOTS) ? SLOTS : int'(top_mark[c]);
                for (k = top; k > 1 && !done; k--)
                begin
                    if (slot_vals[c][k - 1] == r.value)
                    begin
                        o.result_index = 8'(k - 1);
                        done = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    function automatic fsht_rsp_t queue_request(input logic [1:0] cmd, input logic [31:0] val,
                                                input logic [7:0] slot);
        fsht_req_t r;
        r.command = cmd;
        r.value = val;
        r.slot_index = slot;
        queued_requests.push_back(r);
        case (cmd)
            CMD_ADD: adds_sent++;
            CMD_REMOVE: removes_sent++;
            CMD_FIND: finds_sent++;
            default: others_sent++;
        endcase
        if (cmd != CMD_NONE)
            item_count++;
        return apply_table_op(PLAN, r);
    endfunction

    function automatic int pick_busy_slot();
        int busy [$];
        int k;
        for (k = 1; k < SLOTS; k++)
            if (slot_vals[PLAN][k] != '0)
                busy.push_back(k);
        if (busy.size() == 0)
            return 0;
        return busy[$urandom_range(0, busy.size() - 1)];
    endfunction

    function automatic int busy_count();
        int n;
        int k;
        n = 0;
        for (k = 1; k < SLOTS; k++)
            if (slot_vals[PLAN][k] != '0)
                n++;
        return n;
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r <= 3)
            return 32'($urandom_range(1, 15));
        return $urandom;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
                predicted_responses.push_back(apply_table_op(LIVE, req));
            if (!req_valid || req_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (queued_requests.size() > 0)
                begin
                    req <= queued_requests.pop_front();
                    req_valid <= 1'b1;
                    if (queued_requests.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 7);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        fsht_rsp_t want;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                responses_seen <= responses_seen + 1;
                case (rsp.status)
                    STAT_OK: ok_seen++;
                    STAT_MISMATCH: mismatch_seen++;
                    STAT_FULL: full_seen++;
                    default: ;
                endcase
                if (predicted_responses.size() == 0)
                    flag_error($sformatf("response %0d/%0d arrived with no request outstanding",
                                         rsp.result_index, rsp.status));
                else
                begin
                    want = predicted_responses.pop_front();
                    if (rsp.result_index !== want.result_index)
                        flag_error($sformatf("response %0d: result_index %0d, expected %0d",
                                             responses_seen, rsp.result_index,
                                             want.result_index));
                    if (rsp.status !== want.status)
                        flag_error($sformatf("response %0d: status %0d, expected %0d",
                                             responses_seen, rsp.status, want.status));
                end
            end
            if (hold_active)
                rsp_ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                rsp_ready <= 1'b0;
            end
            else if (responses_seen + QUIET_TAIL < request_total && $urandom_range(0, 7) == 0)
            begin
                recv_gap <= $urandom_range(0, 6);
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_active <= 1'b0;
            hold_cycles <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_active)
        begin
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles == HOLD_LEN - 1)
            begin
                hold_active <= 1'b0;
                hold_done <= 1'b1;
            end
        end
        else if (!hold_done && responses_seen >= HOLD_AFTER)
            hold_active <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        fsht_rsp_t plan_rsp;
        int sel;
        int busy;
        int k;
        logic [31:0] v;
        bit filled;

        for (k = 0; k < SLOTS; k++)
        begin
            slot_vals[PLAN][k] = '0;
            slot_vals[LIVE][k] = '0;
        end
        low_free[PLAN] = 1;
        low_free[LIVE] = 1;
        top_mark[PLAN] = 1;
        top_mark[LIVE] = 1;

        void'(queue_request(CMD_FIND, 32'h0, 8'h00));
        void'(queue_request(CMD_FIND, 32'hFFFF_FFFF, 8'hFF));
        void'(queue_request(CMD_REMOVE, 32'h0, 8'h00));
        void'(queue_request(CMD_REMOVE, 32'h0, 8'h05));
        void'(queue_request(CMD_FIND, 32'h0, 8'h00));
        void'(queue_request(CMD_ADD, 32'hFFFF_FFFF, 8'hFF));
        void'(queue_request(CMD_ADD, 32'h0, 8'h00));
        void'(queue_request(CMD_ADD, 32'h1234_5678, 8'h00));
        void'(queue_request(CMD_ADD, 32'h0000_0001, 8'hAA));
        void'(queue_request(CMD_REMOVE, 32'h0000_0002, 8'h03));
        void'(queue_request(CMD_REMOVE, 32'h0000_0001, 8'h03));
        void'(queue_request(CMD_REMOVE, 32'h0, 8'hFF));
        void'(queue_request(CMD_FIND, 32'h0, 8'h55));
        void'(queue_request(CMD_FIND, 32'h1234_5678, 8'h00));
        void'(queue_request(CMD_NONE, 32'hDEAD_BEEF, 8'h5A));
        void'(queue_request(CMD_NONE, 32'h0, 8'h00));
        void'(queue_request(CMD_REMOVE, 32'hFFFF_FFFF, 8'h01));
        void'(queue_request(CMD_ADD, 32'hA5A5_A5A5, 8'h00));
        void'(queue_request(CMD_FIND, 32'hFFFF_FFFF, 8'h00));
        void'(queue_request(CMD_REMOVE, 32'hFFFF_FFFF, 8'hFF));
        void'(queue_request(CMD_ADD, 32'h5A5A_5A5A, 8'h00));

        item_count = 0;
        filled = 1'b0;
        while (item_count < RANDOM_ITEMS)
        begin
            if (!filled && item_count >= 350)
            begin
                do
                    plan_rsp = queue_request(CMD_ADD, 32'($urandom_range(1, 32'hFFFF_FFFE)) | 32'h1,
                                             8'($urandom));
                while (plan_rsp.status != STAT_FULL);
                void'(queue_request(CMD_ADD, 32'h0, 8'($urandom)));
                void'(queue_request(CMD_ADD, $urandom, 8'($urandom)));
                void'(queue_request(CMD_FIND, $urandom, 8'($urandom)));
                repeat (170)
                begin
                    k = pick_busy_slot();
                    void'(queue_request(CMD_REMOVE, slot_vals[PLAN][k], 8'(k)));
                end
                filled = 1'b1;
            end
            sel = $urandom_range(0, 99);
            busy = busy_count();
            if (busy > 180 && sel < 40)
                sel = sel + 40;
            if (sel < 40)
                void'(queue_request(CMD_ADD, pick_value(), 8'($urandom)));
            else if (sel < 68)
            begin
                k = pick_busy_slot();
                if (k != 0 && $urandom_range(0, 4) != 0)
                    void'(queue_request(CMD_REMOVE, slot_vals[PLAN][k], 8'(k)));
                else
                begin
                    k = $urandom_range(0, SLOTS - 1);
                    case ($urandom_range(0, 2))
                        0: v = '0;
                        1: v = $urandom;
                        default: v = slot_vals[PLAN][k] ^ (32'd1 << $urandom_range(0, 31));
                    endcase
                    void'(queue_request(CMD_REMOVE, v, 8'(k)));
                end
            end
            else if (sel < 94)
            begin
                k = pick_busy_slot();
                if (k != 0 && $urandom_range(0, 2) != 0)
                    void'(queue_request(CMD_FIND, slot_vals[PLAN][k], 8'($urandom)));
                else
                    void'(queue_request(CMD_FIND, pick_value(), 8'($urandom)));
            end
            else
                void'(queue_request(CMD_NONE, $urandom, 8'($urandom)));
        end
        request_total = queued_requests.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (queued_requests.size() != 0 || req_valid || predicted_responses.size() != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);

        $display("Ran %0d requests: %0d add, %0d remove, %0d find, %0d unused command.",
                 request_total, adds_sent, removes_sent, finds_sent, others_sent);
        $display("Saw %0d ok, %0d mismatch, %0d full; response side held off %0d cycles once.",
                 ok_seen, mismatch_seen, full_seen, hold_cycles);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
